FILE: hdl/perspective_edge_projector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge projector
// Concurrent checks that sample on clk and stay quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_EDGE_PROJECTOR_ASSERT_SVH
`define PERSPECTIVE_EDGE_PROJECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pep assertion failed");

// next-cycle implication
`define PEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pep assertion failed");

`else

`define PEP_ASSERT_IMP(lbl, ante, cons)
`define PEP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/pep_pkg.sv
// ----------------------------------------------------------------------------
// pep_pkg
// Shared widths, register indexes and reset values of the edge projector.
// ----------------------------------------------------------------------------
package pep_pkg;

  localparam int CW        = 32;  // coordinate and config data width
  localparam int CFG_IDX_W = 3;
  localparam int VP_MARGIN = 10;  // viewport margin in pixels

  // projection quotient: 49 bits, clamped to 2^48
  localparam int             PROJ_QW  = 49;
  localparam logic [PROJ_QW-1:0] PROJ_LIM = {1'b1, 48'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X        = 3'd0,
    CFG_CAMERA_Y        = 3'd1,
    CFG_CAMERA_Z        = 3'd2,
    CFG_FOCAL_LENGTH    = 3'd3,
    CFG_NEAR_PLANE      = 3'd4,
    CFG_VIEWPORT_WIDTH  = 3'd5,
    CFG_VIEWPORT_HEIGHT = 3'd6
  } cfg_idx_t;

  localparam logic signed [CW-1:0] CAMERA_X_RST = 32'sh0000_0000;
  localparam logic signed [CW-1:0] CAMERA_Y_RST = 32'sh0000_0000;
  localparam logic signed [CW-1:0] CAMERA_Z_RST = 32'shFFCE_0000;
  localparam logic [30:0]          FOCAL_RST    = 31'd3276800;
  localparam logic [30:0]          NEAR_RST     = 31'd65536;
  localparam logic [11:0]          VP_W_RST     = 12'd620;
  localparam logic [11:0]          VP_H_RST     = 12'd460;

endpackage

FILE: hdl/pep_udiv.sv
// ----------------------------------------------------------------------------
// pep_udiv
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lockstep with a sideband that rides along. Flags quotients >= 2^QW.
// ----------------------------------------------------------------------------
`include "perspective_edge_projector_assert.svh"

module pep_udiv #(
  parameter int LANES = 1,
  parameter int NW    = 34,
  parameter int DW    = 33,
  parameter int QW    = 1,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NW-1:0]     in_num,
  input  logic [LANES-1:0][DW-1:0]     in_den,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][QW-1:0]     out_quo,
  output logic [LANES-1:0]             out_ovf,
  output logic [SW-1:0]                out_side
);

  localparam int HW    = NW - QW;
  localparam int CMP_W = (HW > DW) ? HW : DW;

  logic [QW:0]                     v_r, v_nxt;
  logic [LANES-1:0][DW-1:0]        rem_r  [QW+1];
  logic [LANES-1:0][DW-1:0]        rem_nxt[QW+1];
  logic [LANES-1:0][QW-1:0]        low_r  [QW+1];
  logic [LANES-1:0][QW-1:0]        low_nxt[QW+1];
  logic [LANES-1:0][QW-1:0]        quo_r  [QW+1];
  logic [LANES-1:0][QW-1:0]        quo_nxt[QW+1];
  logic [LANES-1:0][DW-1:0]        den_r  [QW+1];
  logic [LANES-1:0][DW-1:0]        den_nxt[QW+1];
  logic [LANES-1:0]                ovf_r  [QW+1];
  logic [LANES-1:0]                ovf_nxt[QW+1];
  logic [SW-1:0]                   side_r [QW+1];
  logic [SW-1:0]                   side_nxt[QW+1];

  always_comb begin
    logic [HW-1:0] hi;
    logic [DW:0]   t;
    logic          ge;
    v_nxt = {v_r[QW-1:0], in_valid};
    // entry stage: the high part must already be below the divisor
    for (int l = 0; l < LANES; l++) begin
      hi              = in_num[l][NW-1:QW];
      ovf_nxt[0][l]   = CMP_W'(hi) >= CMP_W'(in_den[l]);
      rem_nxt[0][l]   = DW'(hi);
      low_nxt[0][l]   = in_num[l][QW-1:0];
      quo_nxt[0][l]   = '0;
    end
    den_nxt[0]  = in_den;
    side_nxt[0] = in_side;
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t  = {rem_r[k-1][l], low_r[k-1][l][QW-1]};
        ge = t >= {1'b0, den_r[k-1][l]};
        rem_nxt[k][l] = ge ? DW'(t - {1'b0, den_r[k-1][l]}) : DW'(t);
        low_nxt[k][l] = low_r[k-1][l] << 1;
        quo_nxt[k][l] = (quo_r[k-1][l] << 1) | QW'(ge);
      end
      ovf_nxt[k]  = ovf_r[k-1];
      den_nxt[k]  = den_r[k-1];
      side_nxt[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_nxt;
      ovf_r  <= ovf_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_ovf   = ovf_r[QW];
  assign out_side  = side_r[QW];

  `PEP_ASSERT_NXT(a_div_enter, en && in_valid, v_r[0])
  `PEP_ASSERT_NXT(a_div_hold, !en, $stable(v_r) && $stable(quo_r[QW]))
  `PEP_ASSERT_IMP(a_div_rem, v_r[QW] && !ovf_r[QW][0], rem_r[QW][0] < den_r[QW][0])

endmodule

FILE: hdl/perspective_edge_projector.sv
// ----------------------------------------------------------------------------
// perspective_edge_projector: one edge per cycle sustained while out_stall
// does not hold the pipeline.
// Depth is set by the two bit-per-stage dividers (clip, projection); the
// window-span divide is a two-stage reciprocal multiply.
// Synchronous reset clears valid bits and config registers to defaults.
// ----------------------------------------------------------------------------
`include "perspective_edge_projector_assert.svh"

module perspective_edge_projector #(
  parameter int WINDOW_MIN  = -25,
  parameter int WINDOW_SPAN = 50,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pep_pkg::CW-1:0]       in_start_x,
  input  logic signed [pep_pkg::CW-1:0]       in_start_y,
  input  logic signed [pep_pkg::CW-1:0]       in_start_z,
  input  logic signed [pep_pkg::CW-1:0]       in_end_x,
  input  logic signed [pep_pkg::CW-1:0]       in_end_y,
  input  logic signed [pep_pkg::CW-1:0]       in_end_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_visible,
  output logic signed [pep_pkg::CW-1:0]       out_screen_x1,
  output logic signed [pep_pkg::CW-1:0]       out_screen_y1,
  output logic signed [pep_pkg::CW-1:0]       out_screen_x2,
  output logic signed [pep_pkg::CW-1:0]       out_screen_y2,
  input  logic                                cfg_we,
  input  logic [pep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pep_pkg::CW-1:0]              cfg_wdata
);

  import pep_pkg::*;

  localparam int F       = FRAC_BITS;
  localparam int QV      = (F + 14 > 33) ? F + 14 : 33;
  localparam int CLIP_NW = 33 + F;
  localparam int PW      = 34 + F;
  localparam int GW      = QV + 3;
  localparam longint WMIN_Q   = longint'(WINDOW_MIN) * (longint'(1) << F);
  localparam longint MARGIN_Q = longint'(VP_MARGIN) << F;
  localparam logic signed [50:0] WMIN51 = 51'(WMIN_Q);

  // window-span divide by reciprocal: exact below 2^RK; values at or above WINDOW_SPAN << QV saturate
  localparam int SL   = $clog2(WINDOW_SPAN);
  localparam int RK   = QV + SL;
  localparam int RH   = RK / 2;
  localparam int RS   = RK + SL;
  localparam int RMW  = RK + 1;
  localparam int PLW  = RH + RMW;
  localparam int PHW  = RK - RH + RMW;
  localparam int SUMW = RK + RMW + 1;
  localparam longint RECIP_L = ((longint'(1) << RS) + longint'(WINDOW_SPAN) - 1) /
                               longint'(WINDOW_SPAN);
  localparam logic [RMW-1:0] RECIP   = RMW'(RECIP_L);
  localparam logic [61:0]    MAP_CAP = 62'(longint'(WINDOW_SPAN)) << QV;

  typedef struct packed {
    logic                 vis;
    logic                 clip_any;
    logic                 clip1;     // first endpoint is the one moved
    logic signed [31:0]   x1;
    logic signed [31:0]   y1;
    logic signed [31:0]   x2;
    logic signed [31:0]   y2;
    logic [30:0]          z1;
    logic [30:0]          z2;
  } clip_side_t;

  typedef struct packed {
    logic       vis;
    logic [3:0] sg;
  } lane_side_t;

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // ---------------- config registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [30:0]        focal_r, near_r;
  logic [11:0]        vp_w_r, vp_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= CAMERA_X_RST;
      cam_y_r <= CAMERA_Y_RST;
      cam_z_r <= CAMERA_Z_RST;
      focal_r <= FOCAL_RST;
      near_r  <= NEAR_RST;
      vp_w_r  <= VP_W_RST;
      vp_h_r  <= VP_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X:        cam_x_r <= cfg_wdata;
        CFG_CAMERA_Y:        cam_y_r <= cfg_wdata;
        CFG_CAMERA_Z:        cam_z_r <= cfg_wdata;
        CFG_FOCAL_LENGTH:    focal_r <= cfg_wdata[30:0];
        CFG_NEAR_PLANE:      near_r  <= cfg_wdata[30:0];
        CFG_VIEWPORT_WIDTH:  vp_w_r  <= cfg_wdata[11:0];
        CFG_VIEWPORT_HEIGHT: vp_h_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- A: camera space
  logic               a_v_r;
  logic signed [31:0] a_c_r [6];   // x1 y1 z1 x2 y2 z2

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r[0] <= sub_sat(in_start_x, cam_x_r);
      a_c_r[1] <= sub_sat(in_start_y, cam_y_r);
      a_c_r[2] <= sub_sat(in_start_z, cam_z_r);
      a_c_r[3] <= sub_sat(in_end_x, cam_x_r);
      a_c_r[4] <= sub_sat(in_end_y, cam_y_r);
      a_c_r[5] <= sub_sat(in_end_z, cam_z_r);
    end
  end

  // ---------------- B: near-plane test, clip parameter divide
  logic [30:0]        nearq;
  logic               vis1, vis2;
  logic signed [31:0] zb, zv;
  logic [32:0]        cnum, cden;
  clip_side_t         b_side;

  always_comb begin
    nearq = (near_r == '0) ? 31'd1 : near_r;
    vis1  = $signed({a_c_r[2][31], a_c_r[2]}) > $signed({2'b00, nearq});
    vis2  = $signed({a_c_r[5][31], a_c_r[5]}) > $signed({2'b00, nearq});
    b_side.vis      = vis1 || vis2;
    b_side.clip_any = vis1 ^ vis2;
    b_side.clip1    = vis2 && !vis1;
    b_side.x1       = a_c_r[0];
    b_side.y1       = a_c_r[1];
    b_side.x2       = a_c_r[3];
    b_side.y2       = a_c_r[4];
    b_side.z1       = vis1 ? a_c_r[2][30:0] : nearq;
    b_side.z2       = vis2 ? a_c_r[5][30:0] : nearq;
    zb   = b_side.clip1 ? a_c_r[2] : a_c_r[5];
    zv   = b_side.clip1 ? a_c_r[5] : a_c_r[2];
    cnum = {2'b00, nearq} - {zb[31], zb};
    cden = {zv[31], zv} - {zb[31], zb};
  end

  logic                  k_valid;
  logic [0:0][F-1:0]     k_quo;
  logic [0:0]            k_ovf;
  clip_side_t            k_side;

  pep_udiv #(
    .LANES(1), .NW(CLIP_NW), .DW(33), .QW(F), .SW($bits(clip_side_t))
  ) u_clip_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (a_v_r),
    .in_num   ({cnum, {F{1'b0}}}),
    .in_den   (cden),
    .in_side  (b_side),
    .out_valid(k_valid),
    .out_quo  (k_quo),
    .out_ovf  (k_ovf),
    .out_side (k_side)
  );

  // ---------------- C1: edge deltas
  logic               c1_v_r;
  clip_side_t         c1_s_r;
  logic [F-1:0]       c1_t_r;
  logic signed [32:0] c1_dx_r, c1_dy_r;
  logic signed [31:0] k_xb, k_xv, k_yb, k_yv;

  always_comb begin
    k_xb = k_side.clip1 ? k_side.x1 : k_side.x2;
    k_xv = k_side.clip1 ? k_side.x2 : k_side.x1;
    k_yb = k_side.clip1 ? k_side.y1 : k_side.y2;
    k_yv = k_side.clip1 ? k_side.y2 : k_side.y1;
  end

  // ---------------- C2: delta * t
  logic                c2_v_r;
  clip_side_t          c2_s_r;
  logic signed [PW-1:0] c2_px_r, c2_py_r;

  // ---------------- C3: move the hidden endpoint
  logic               c3_v_r, c3_vis_r;
  logic signed [31:0] c3_p_r [4];    // x1 y1 x2 y2
  logic [30:0]        c3_z_r [2];
  logic signed [31:0] c2_xb, c2_yb;
  logic signed [PW-1:0] c2_shx, c2_shy;
  logic signed [33:0] c2_nx, c2_ny;
  logic signed [31:0] c3_p_nxt [4];

  always_comb begin
    c2_xb  = c2_s_r.clip1 ? c2_s_r.x1 : c2_s_r.x2;
    c2_yb  = c2_s_r.clip1 ? c2_s_r.y1 : c2_s_r.y2;
    c2_shx = c2_px_r >>> F;   // floor
    c2_shy = c2_py_r >>> F;
    c2_nx  = {c2_xb[31], c2_xb[31], c2_xb} + c2_shx[33:0];
    c2_ny  = {c2_yb[31], c2_yb[31], c2_yb} + c2_shy[33:0];
    c3_p_nxt[0] = c2_s_r.x1;
    c3_p_nxt[1] = c2_s_r.y1;
    c3_p_nxt[2] = c2_s_r.x2;
    c3_p_nxt[3] = c2_s_r.y2;
    if (c2_s_r.clip_any) begin
      if (c2_s_r.clip1) begin
        c3_p_nxt[0] = c2_nx[31:0];
        c3_p_nxt[1] = c2_ny[31:0];
      end else begin
        c3_p_nxt[2] = c2_nx[31:0];
        c3_p_nxt[3] = c2_ny[31:0];
      end
    end
  end

  // ---------------- C4: |coord| * focal
  logic              c4_v_r, c4_vis_r;
  logic [3:0][61:0]  c4_m_r;
  logic [3:0]        c4_sg_r;
  logic [30:0]       c4_z_r [2];
  logic [31:0]       c3_mag [4];
  logic [62:0]       c3_prod [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      c3_mag[l]  = c3_p_r[l][31] ? (32'(~c3_p_r[l]) + 32'd1) : 32'(c3_p_r[l]);
      c3_prod[l] = {31'd0, c3_mag[l]} * {32'd0, focal_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= k_valid;
      c2_v_r <= c1_v_r;
      c3_v_r <= c2_v_r;
      c4_v_r <= c3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_s_r   <= k_side;
      c1_t_r   <= k_quo[0];
      c1_dx_r  <= {k_xv[31], k_xv} - {k_xb[31], k_xb};
      c1_dy_r  <= {k_yv[31], k_yv} - {k_yb[31], k_yb};
      c2_s_r   <= c1_s_r;
      c2_px_r  <= c1_dx_r * $signed({1'b0, c1_t_r});
      c2_py_r  <= c1_dy_r * $signed({1'b0, c1_t_r});
      c3_vis_r <= c2_s_r.vis;
      c3_p_r   <= c3_p_nxt;
      c3_z_r[0] <= c2_s_r.z1;
      c3_z_r[1] <= c2_s_r.z2;
      c4_vis_r <= c3_vis_r;
      c4_z_r   <= c3_z_r;
      for (int l = 0; l < 4; l++) begin
        c4_m_r[l]  <= c3_prod[l][61:0];
        c4_sg_r[l] <= c3_p_r[l][31];
      end
    end
  end

  // ---------------- D: projection divide by depth
  logic                   d_valid;
  logic [3:0][PROJ_QW-1:0] d_quo;
  logic [3:0]             d_ovf;
  lane_side_t             d_side_in, d_side;

  assign d_side_in.vis = c4_vis_r;
  assign d_side_in.sg  = c4_sg_r;

  pep_udiv #(
    .LANES(4), .NW(62), .DW(31), .QW(PROJ_QW), .SW($bits(lane_side_t))
  ) u_proj_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c4_v_r),
    .in_num   (c4_m_r),
    .in_den   ({c4_z_r[1], c4_z_r[1], c4_z_r[0], c4_z_r[0]}),
    .in_side  (d_side_in),
    .out_valid(d_valid),
    .out_quo  (d_quo),
    .out_ovf  (d_ovf),
    .out_side (d_side)
  );

  // ---------------- E1: clamp, sign, offset by window origin
  logic              e1_v_r, e1_vis_r;
  logic [3:0][49:0]  e1_dm_r;
  logic [3:0]        e1_ds_r;
  logic [PROJ_QW-1:0]  d_lim [4];
  logic signed [50:0]  d_pa [4];
  logic signed [50:0]  d_off [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      d_lim[l] = (d_ovf[l] || d_quo[l] > PROJ_LIM) ? PROJ_LIM : d_quo[l];
      d_pa[l]  = $signed({2'b00, d_lim[l]});
      d_off[l] = (d_side.sg[l] ? -d_pa[l] : d_pa[l]) - WMIN51;
    end
  end

  // ---------------- E2: scale by viewport size
  logic              e2_v_r, e2_vis_r;
  logic [3:0][61:0]  e2_m_r;
  logic [3:0]        e2_ds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= d_valid;
      e2_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_vis_r <= d_side.vis;
      e2_vis_r <= e1_vis_r;
      e2_ds_r  <= e1_ds_r;
      for (int l = 0; l < 4; l++) begin
        e1_dm_r[l] <= d_off[l][50] ? 50'(-d_off[l]) : 50'(d_off[l]);
        e1_ds_r[l] <= d_off[l][50];
        // odd lanes carry y
        e2_m_r[l]  <= {12'd0, e1_dm_r[l]} * {50'd0, (l % 2 == 1) ? vp_h_r : vp_w_r};
      end
    end
  end

  // ---------------- F1: partial products with the span reciprocal
  logic                  f1_v_r, f1_vis_r;
  logic [3:0]            f1_sg_r, f1_ovf_r;
  logic [3:0][PLW-1:0]   f1_plo_r;
  logic [3:0][PHW-1:0]   f1_phi_r;

  // ---------------- F2: sum and shift down to the quotient
  logic                  m_v_r, m_vis_r;
  logic [3:0]            m_sg_r, m_ovf_r;
  logic [3:0][QV-1:0]    m_quo_r;
  logic [SUMW-1:0]       f2_sum [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      f2_sum[l] = (SUMW'(f1_phi_r[l]) << RH) + SUMW'(f1_plo_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      m_v_r  <= 1'b0;
    end else if (en) begin
      f1_v_r <= e2_v_r;
      m_v_r  <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_vis_r <= e2_vis_r;
      f1_sg_r  <= e2_ds_r;
      m_vis_r  <= f1_vis_r;
      m_sg_r   <= f1_sg_r;
      m_ovf_r  <= f1_ovf_r;
      for (int l = 0; l < 4; l++) begin
        f1_ovf_r[l] <= e2_m_r[l] >= MAP_CAP;
        f1_plo_r[l] <= PLW'(e2_m_r[l][RH-1:0]) * PLW'(RECIP);
        f1_phi_r[l] <= PHW'(e2_m_r[l][RK-1:RH]) * PHW'(RECIP);
        m_quo_r[l]  <= f2_sum[l][RS+QV-1:RS];
      end
    end
  end

  // ---------------- G: margin, y flip, saturate
  logic [QV-1:0]        g_mag [4];
  logic signed [GW-1:0] g_m [4];
  logic signed [GW-1:0] g_sum [4];
  logic signed [31:0]   g_sat [4];
  logic signed [GW-1:0] g_base_x, g_base_y;

  always_comb begin
    g_base_x = GW'(MARGIN_Q);
    g_base_y = GW'(MARGIN_Q) + (GW'(vp_h_r) << F);
    for (int l = 0; l < 4; l++) begin
      // an overflowed quotient saturates the same way as the true one
      g_mag[l] = m_ovf_r[l] ? '1 : m_quo_r[l];
      g_m[l]   = m_sg_r[l] ? -$signed({3'b000, g_mag[l]}) : $signed({3'b000, g_mag[l]});
      g_sum[l] = (l % 2 == 1) ? (g_base_y - g_m[l]) : (g_base_x + g_m[l]);
      if (g_sum[l][GW-1:31] == {(GW-31){g_sum[l][GW-1]}}) begin
        g_sat[l] = g_sum[l][31:0];
      end else begin
        g_sat[l] = g_sum[l][GW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      if (!m_vis_r) begin
        g_sat[l] = '0;
      end
    end
  end

  logic               out_visible_r;
  logic signed [31:0] out_s_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_visible_r <= m_vis_r;
      out_s_r       <= g_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_visible   = out_visible_r;
  assign out_screen_x1 = out_s_r[0];
  assign out_screen_y1 = out_s_r[1];
  assign out_screen_x2 = out_s_r[2];
  assign out_screen_y2 = out_s_r[3];

  `PEP_ASSERT_IMP(a_clip_t_range, k_valid && k_side.clip_any, !k_ovf[0])
  `PEP_ASSERT_IMP(a_depth_nonzero, c4_v_r && c4_vis_r, c4_z_r[0] != '0 && c4_z_r[1] != '0)
  `PEP_ASSERT_IMP(a_culled_zero, out_valid_r && !out_visible_r, out_s_r[0] == '0 && out_s_r[1] == '0 && out_s_r[2] == '0 && out_s_r[3] == '0)

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Edge projector testbench
// Drives line edges through the valid/stall input channel and checks every
// projected result, field by field and in order, against an in-bench model.
// The run covers default and extreme camera and viewport settings, and
// random edges under sender and receiver idling and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pep_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // no register here
  localparam longint ONE_Q    = 64'sd65536;
  localparam longint PROJ_MAX = 64'sd1 <<< 48;
  localparam longint SMALL_R  = 64'sd200 * ONE_Q;
  localparam int     WATCHDOG = 20000;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
  } edge_t;

  typedef struct {
    logic               visible;
    logic signed [31:0] x1, y1, x2, y2;
  } screen_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic signed [31:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic signed [31:0] in_end_x = 0, in_end_y = 0, in_end_z = 0;
  logic out_valid, out_stall = 0, out_visible;
  logic signed [31:0] out_screen_x1, out_screen_y1, out_screen_x2, out_screen_y2;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  perspective_edge_projector dut (.*);

  always #10 clk = ~clk;

  // configuration mirror
  longint cam_x = 0, cam_y = 0, cam_z = -3276800;
  longint focal = 3276800, near_q = 65536, vp_w = 620, vp_h = 460;

  screen_t expected_q[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_visible = 0;
  int send_idle = 0, recv_idle = 0, hold_left = 0, quiet = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void map_point(longint c[3], output longint sx, output longint sy);
    longint px, py;
    px = (c[0] * focal) / c[2];
    py = (c[1] * focal) / c[2];
    if (px > PROJ_MAX) px = PROJ_MAX;
    if (px < -PROJ_MAX) px = -PROJ_MAX;
    if (py > PROJ_MAX) py = PROJ_MAX;
    if (py < -PROJ_MAX) py = -PROJ_MAX;
    sx = sat32(10 * ONE_Q + ((px + 25 * ONE_Q) * vp_w) / 50);
    sy = sat32((10 + vp_h) * ONE_Q - ((py + 25 * ONE_Q) * vp_h) / 50);
  endfunction

  function automatic screen_t project_edge(edge_t e);
    screen_t r;
    longint a[3], b[3], nq, t, sx, sy;
    bit va, vb;
    nq = (near_q < 1) ? 1 : near_q;
    a[0] = sat32(longint'(e.sx) - cam_x);
    a[1] = sat32(longint'(e.sy) - cam_y);
    a[2] = sat32(longint'(e.sz) - cam_z);
    b[0] = sat32(longint'(e.ex) - cam_x);
    b[1] = sat32(longint'(e.ey) - cam_y);
    b[2] = sat32(longint'(e.ez) - cam_z);
    va = a[2] > nq;
    vb = b[2] > nq;
    r = '{1'b0, 0, 0, 0, 0};
    if (!va && !vb) return r;
    if (!va) begin
      t = ((nq - a[2]) * ONE_Q) / (b[2] - a[2]);
      a[0] += ((b[0] - a[0]) * t) >>> 16;
      a[1] += ((b[1] - a[1]) * t) >>> 16;
      a[2] = nq;
    end
    if (!vb) begin
      t = ((nq - b[2]) * ONE_Q) / (a[2] - b[2]);
      b[0] += ((a[0] - b[0]) * t) >>> 16;
      b[1] += ((a[1] - b[1]) * t) >>> 16;
      b[2] = nq;
    end
    r.visible = 1'b1;
    map_point(a, sx, sy);
    r.x1 = sx[31:0];
    r.y1 = sy[31:0];
    map_point(b, sx, sy);
    r.x2 = sx[31:0];
    r.y2 = sy[31:0];
    return r;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    errors++;
    $display("ERROR result %0d %s: got %0d expected %0d", n_checked, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      screen_t w;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_visible !== w.visible) report("visible", out_visible, w.visible);
        if (out_screen_x1 !== w.x1) report("screen_x1", out_screen_x1, w.x1);
        if (out_screen_y1 !== w.y1) report("screen_y1", out_screen_y1, w.y1);
        if (out_screen_x2 !== w.x2) report("screen_x2", out_screen_x2, w.x2);
        if (out_screen_y2 !== w.y2) report("screen_y2", out_screen_y2, w.y2);
        if (w.visible) n_visible++;
      end
      n_checked++;
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", expected_q.size());
      $display("perspective_edge_projector: mismatch");
      $finish;
    end
  end

  task automatic send_edge(edge_t e);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= e.sx;
    in_start_y <= e.sy;
    in_start_z <= e.sz;
    in_end_x   <= e.ex;
    in_end_y   <= e.ey;
    in_end_z   <= e.ez;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(project_edge(e));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // writes all seven registers plus the unused index, then lowers the enable
  task automatic set_config(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] f, logic [31:0] nr, logic [31:0] w,
                            logic [31:0] h);
    logic [31:0] vals[7];
    vals = '{cx, cy, cz, f, nr, w, h};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    cam_x  = longint'(signed'(cx));
    cam_y  = longint'(signed'(cy));
    cam_z  = longint'(signed'(cz));
    focal  = longint'(f[30:0]);
    near_q = longint'(nr[30:0]);
    vp_w   = longint'(w[11:0]);
    vp_h   = longint'(h[11:0]);
  endtask

  function automatic logic signed [31:0] rand_coord(bit is_z);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        if (is_z) return 32'(longint'($urandom_range(0, 160 * 65536)) - 60 * ONE_Q);
        return 32'(longint'($urandom_range(0, 2 * SMALL_R)) - SMALL_R);
      end
    endcase
  endfunction

  function automatic edge_t rand_edge();
    edge_t e;
    e.sx = rand_coord(0);
    e.sy = rand_coord(0);
    e.sz = rand_coord(1);
    e.ex = rand_coord(0);
    e.ey = rand_coord(0);
    e.ez = rand_coord(1);
    return e;
  endfunction

  task automatic directed_edges();
    // world z -49 is exactly at the default near plane
    send_edge('{32'sd65536, 32'sd65536, 32'sd0, -32'sd65536, -32'sd65536, 32'sd655360});
    send_edge('{32'sd0, 32'sd0, -32'sd3276800, 32'sd65536, 32'sd0, -32'sd3211264});
    send_edge('{32'sd0, 32'sd0, -32'sd6553600, 32'sd655360, 32'sd655360, 32'sd0});
    send_edge('{32'sd655360, -32'sd655360, 32'sd0, 32'sd0, 32'sd0, -32'sd6553600});
    send_edge('{32'sd0, 32'sd0, -32'sd3211264, 32'sd65536, 32'sd65536, 32'sd65536});
    send_edge('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_edge('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_edge('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_edge('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    for (int i = 0; i < 6; i++) send_edge(rand_edge());
  endtask

  task automatic test_defaults();
    directed_edges();
    drain();
  endtask

  task automatic test_corner_settings();
    // zero near plane, zero focal length, zero viewport
    set_config(0, 0, 32'hFFCE_0000, 0, 0, 0, 0);
    directed_edges();
    drain();
    // extremes of every register
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    directed_edges();
    drain();
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 1);
    directed_edges();
    drain();
  endtask

  task automatic test_random_phase(int s_idle, int r_idle, int count);
    logic [31:0] f, nr;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int blk = 0; blk < 3; blk++) begin
      f  = $urandom_range(1) ? 32'd3276800 : $urandom;
      nr = $urandom_range(1) ? 32'd65536 : $urandom_range(0, 20 * 65536);
      set_config(32'(longint'($urandom_range(0, 20 * 65536)) - 10 * ONE_Q),
                 $urandom_range(3) == 0 ? $urandom : 32'd0,
                 32'(longint'($urandom_range(0, 20 * 65536)) - 60 * ONE_Q),
                 f, nr, $urandom_range(0, 4095), $urandom_range(0, 4095));
      for (int i = 0; i < count / 3; i++) send_edge(rand_edge());
      drain();
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_left <= 400;
    for (int i = 0; i < 200; i++) send_edge(rand_edge());
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_corner_settings();
    test_random_phase(27, 73, 540);
    test_random_phase(73, 27, 540);
    test_random_phase(0, 0, 540);
    test_backpressure();
    $display("sent %0d edges, checked %0d results, %0d visible", n_sent, n_checked,
             n_visible);
    $display("covered defaults, zero and extreme registers, idling and a long hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("perspective_edge_projector: match");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_q.size());
      $display("perspective_edge_projector: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pep_pkg.sv
hdl/pep_udiv.sv
hdl/perspective_edge_projector.sv
sim/testbench.sv
